// ===== rtl/i2cmbe_pkg.sv =====
// Shared definitions for the I2C master byte engine: command codes,
// reset constants and the packed request and result types.
// No dependencies.
package i2cmbe_pkg;

  localparam int unsigned DataW = 8;
  localparam int unsigned CmdW  = 3;

  localparam logic [CmdW-1:0] CMD_NONE  = 3'd0;
  localparam logic [CmdW-1:0] CMD_START = 3'd1;
  localparam logic [CmdW-1:0] CMD_STOP  = 3'd2;
  localparam logic [CmdW-1:0] CMD_WRITE = 3'd3;
  localparam logic [CmdW-1:0] CMD_READ  = 3'd4;
  localparam logic [CmdW-1:0] CMD_WAIT  = 3'd5;

  localparam logic [DataW-1:0] ACK_TIMEOUT_RST = 8'd100;

  typedef struct packed {
    logic [CmdW-1:0]  req_type;
    logic [DataW-1:0] wr_data;
    logic             send_ack;
    logic             sda_in;
  } req_t;

  typedef struct packed {
    logic             scl_out;
    logic             sda_out;
    logic             busy_res;
    logic             done_res;
    logic [DataW-1:0] rd_data;
    logic             ack_fail;
  } res_t;

endpackage

// ===== rtl/i2cmbe_req_if.sv =====
// Tick request channel of the I2C master byte engine.
// Depends on i2cmbe_pkg for field widths.
interface i2cmbe_req_if;
  logic                          valid;
  logic                          ready;
  logic [i2cmbe_pkg::CmdW-1:0]   req_type;
  logic [i2cmbe_pkg::DataW-1:0]  wr_data;
  logic                          send_ack;
  logic                          sda_in;

  modport source (output valid, req_type, wr_data, send_ack, sda_in, input ready);
  modport sink (input valid, req_type, wr_data, send_ack, sda_in, output ready);
endinterface

// ===== rtl/i2cmbe_res_if.sv =====
// Tick result channel of the I2C master byte engine.
// Depends on i2cmbe_pkg for field widths.
interface i2cmbe_res_if;
  logic                          valid;
  logic                          ready;
  logic                          scl_out;
  logic                          sda_out;
  logic                          busy_res;
  logic                          done_res;
  logic [i2cmbe_pkg::DataW-1:0]  rd_data;
  logic                          ack_fail;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, rd_data, ack_fail,
                  input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, rd_data, ack_fail,
                output ready);
endinterface

// ===== rtl/i2cmbe_cfg_if.sv =====
// Configuration write channel carrying the acknowledge timeout.
// Depends on i2cmbe_pkg for the data width.
interface i2cmbe_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [i2cmbe_pkg::DataW-1:0]  ack_timeout;

  modport source (output valid, ack_timeout, input ready);
  modport sink (input valid, ack_timeout, output ready);
endinterface

// ===== rtl/i2cmbe_core.sv =====
// Bus sequencer state and its single-tick next-state logic.
// Depends on i2cmbe_pkg for command codes and the request and result types.
module i2cmbe_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  i2cmbe_pkg::req_t              req_i,
  input  logic [i2cmbe_pkg::DataW-1:0]  ack_timeout_i,
  output i2cmbe_pkg::res_t              res_o
);

  logic [i2cmbe_pkg::CmdW-1:0]  cmd_q, cmd_d;
  logic [1:0]                   phase_q, phase_d;
  logic [3:0]                   bit_idx_q, bit_idx_d;
  logic [i2cmbe_pkg::DataW-1:0] shift_q, shift_d;
  logic [i2cmbe_pkg::DataW-1:0] wait_q, wait_d;
  logic [i2cmbe_pkg::DataW-1:0] rd_q, rd_d;
  logic                         scl_q, scl_d;
  logic                         sda_q, sda_d;
  logic                         ack_choice_q, ack_choice_d;
  logic                         fail_q, fail_d;
  logic                         pend_q, pend_d;
  logic                         done;

  always_comb begin
    cmd_d        = cmd_q;
    phase_d      = phase_q;
    bit_idx_d    = bit_idx_q;
    shift_d      = shift_q;
    wait_d       = wait_q;
    rd_d         = rd_q;
    scl_d        = scl_q;
    sda_d        = sda_q;
    ack_choice_d = ack_choice_q;
    fail_d       = fail_q;
    pend_d       = pend_q;
    done         = 1'b0;

    if ((cmd_q == i2cmbe_pkg::CMD_NONE) &&
        (req_i.req_type inside {[i2cmbe_pkg::CMD_START:i2cmbe_pkg::CMD_WAIT]})) begin
      cmd_d     = req_i.req_type;
      phase_d   = 2'd0;
      bit_idx_d = 4'd0;
      wait_d    = '0;
      pend_d    = 1'b0;
      if (req_i.req_type == i2cmbe_pkg::CMD_WRITE) begin
        shift_d = req_i.wr_data;
      end
      if (req_i.req_type == i2cmbe_pkg::CMD_READ) begin
        shift_d      = '0;
        ack_choice_d = req_i.send_ack;
      end
      if (req_i.req_type == i2cmbe_pkg::CMD_WAIT) begin
        fail_d = 1'b0;
      end
    end

    case (cmd_d)
      i2cmbe_pkg::CMD_START: begin
        case (phase_d)
          2'd0: begin
            sda_d = 1'b1;
            phase_d = 2'd1;
          end
          2'd1: begin
            scl_d = 1'b1;
            phase_d = 2'd2;
          end
          2'd2: begin
            sda_d = 1'b0;
            phase_d = 2'd3;
          end
          default: begin
            scl_d = 1'b0;
            done = 1'b1;
          end
        endcase
      end
      i2cmbe_pkg::CMD_STOP: begin
        case (phase_d)
          2'd0: begin
            scl_d = 1'b0;
            sda_d = 1'b0;
            phase_d = 2'd1;
          end
          2'd1: begin
            scl_d = 1'b1;
            phase_d = 2'd2;
          end
          default: begin
            sda_d = 1'b1;
            if (pend_d) begin
              fail_d = 1'b1;
              pend_d = 1'b0;
            end
            done = 1'b1;
          end
        endcase
      end
      i2cmbe_pkg::CMD_WRITE: begin
        if (!bit_idx_d[3]) begin
          if (phase_d == 2'd0) begin
            scl_d = 1'b0;
            sda_d = shift_d[i2cmbe_pkg::DataW-1];
            phase_d = 2'd1;
          end else begin
            scl_d = 1'b1;
            shift_d = {shift_d[i2cmbe_pkg::DataW-2:0], 1'b0};
            bit_idx_d = bit_idx_d + 4'd1;
            phase_d = 2'd0;
          end
        end else begin
          scl_d = 1'b0;
          done = 1'b1;
        end
      end
      i2cmbe_pkg::CMD_READ: begin
        if (!bit_idx_d[3]) begin
          if (phase_d == 2'd0) begin
            scl_d = 1'b0;
            sda_d = 1'b1;
            phase_d = 2'd1;
          end else begin
            scl_d = 1'b1;
            shift_d = {shift_d[i2cmbe_pkg::DataW-2:0], req_i.sda_in};
            bit_idx_d = bit_idx_d + 4'd1;
            phase_d = 2'd0;
            if (bit_idx_d[3]) begin
              rd_d = shift_d;
            end
          end
        end else begin
          case (phase_d)
            2'd0: begin
              scl_d = 1'b0;
              sda_d = ~ack_choice_d;
              phase_d = 2'd1;
            end
            2'd1: begin
              scl_d = 1'b1;
              phase_d = 2'd2;
            end
            default: begin
              scl_d = 1'b0;
              done = 1'b1;
            end
          endcase
        end
      end
      i2cmbe_pkg::CMD_WAIT: begin
        if (phase_d == 2'd0) begin
          scl_d = 1'b1;
          sda_d = 1'b1;
          phase_d = 2'd1;
        end else if (!req_i.sda_in) begin
          scl_d = 1'b0;
          done = 1'b1;
        end else if (wait_d >= ack_timeout_i) begin
          // The timeout falls straight into the first tick of a stop condition.
          pend_d = 1'b1;
          cmd_d = i2cmbe_pkg::CMD_STOP;
          scl_d = 1'b0;
          sda_d = 1'b0;
          phase_d = 2'd1;
        end else begin
          wait_d = wait_d + 8'd1;
        end
      end
      default: begin
      end
    endcase

    if (done) begin
      cmd_d = i2cmbe_pkg::CMD_NONE;
      phase_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmd_q        <= i2cmbe_pkg::CMD_NONE;
      phase_q      <= 2'd0;
      bit_idx_q    <= 4'd0;
      shift_q      <= '0;
      wait_q       <= '0;
      rd_q         <= '0;
      scl_q        <= 1'b1;
      sda_q        <= 1'b1;
      ack_choice_q <= 1'b0;
      fail_q       <= 1'b0;
      pend_q       <= 1'b0;
    end else if (accept_i) begin
      cmd_q        <= cmd_d;
      phase_q      <= phase_d;
      bit_idx_q    <= bit_idx_d;
      shift_q      <= shift_d;
      wait_q       <= wait_d;
      rd_q         <= rd_d;
      scl_q        <= scl_d;
      sda_q        <= sda_d;
      ack_choice_q <= ack_choice_d;
      fail_q       <= fail_d;
      pend_q       <= pend_d;
    end
  end

  always_comb begin
    res_o.scl_out  = scl_d;
    res_o.sda_out  = sda_d;
    res_o.busy_res = (cmd_d != i2cmbe_pkg::CMD_NONE);
    res_o.done_res = done;
    res_o.rd_data  = rd_d;
    res_o.ack_fail = fail_d;
  end

endmodule

// ===== rtl/i2cmbe_out_buf.sv =====
// Result register with a skid stage in front of the result channel.
// Depends on i2cmbe_pkg for the result type and on i2cmbe_res_if.
module i2cmbe_out_buf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  i2cmbe_pkg::res_t  data_i,
  output logic              ready_o,
  i2cmbe_res_if.source      res_o
);

  i2cmbe_pkg::res_t out_q, skid_q;
  logic             out_valid_q, skid_valid_q;
  logic             out_free;

  assign ready_o  = ~skid_valid_q;
  assign out_free = ~out_valid_q | res_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= push_i;
      end else begin
        out_valid_q  <= push_i;
      end
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q  <= skid_q;
        skid_q <= data_i;
      end else begin
        out_q  <= data_i;
      end
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign res_o.valid    = out_valid_q;
  assign res_o.scl_out  = out_q.scl_out;
  assign res_o.sda_out  = out_q.sda_out;
  assign res_o.busy_res = out_q.busy_res;
  assign res_o.done_res = out_q.done_res;
  assign res_o.rd_data  = out_q.rd_data;
  assign res_o.ack_fail = out_q.ack_fail;

endmodule

// ===== rtl/i2cmbe_timeout_reg.sv =====
// Acknowledge timeout configuration register behind its write channel.
// Depends on i2cmbe_pkg and i2cmbe_cfg_if.
module i2cmbe_timeout_reg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  i2cmbe_cfg_if.sink                    cfg_i,
  output logic [i2cmbe_pkg::DataW-1:0]  ack_timeout_o
);

  logic [i2cmbe_pkg::DataW-1:0] timeout_q;

  assign cfg_i.ready   = 1'b1;
  assign ack_timeout_o = timeout_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= i2cmbe_pkg::ACK_TIMEOUT_RST;
    end else if (cfg_i.valid) begin
      timeout_q <= cfg_i.ack_timeout;
    end
  end

endmodule

// ===== rtl/i2c_master_byte_engine.sv =====
// Top level of the I2C master byte engine.
// Depends on i2cmbe_pkg, the channel interfaces, i2cmbe_core,
// i2cmbe_timeout_reg and i2cmbe_out_buf.
//
// Each transfer on req_i is one bus timing tick: a command (taken only while
// idle) together with the sampled SDA level. Each accepted tick yields exactly
// one transfer on res_o with the driven SCL and SDA levels, busy, done, the
// last read byte and the acknowledge failure flag.
// One tick is accepted every clock cycle while req_i.ready is high; its result
// is registered before it shows on res_o. The sequencer state is updated in
// the accepting cycle, so the next tick can follow immediately.
// If the receiver stalls, one further result is held in a skid stage and
// req_i.ready falls only once both the result register and the skid stage
// are full; it rises again in the cycle after res_o transfers.
// cfg_i writes the acknowledge timeout in ticks; it is always ready and must
// only be written while no command is in progress.
// After reset both bus lines are released high, no command is active, the
// timeout is 100 ticks and the read byte and failure flag are zero.
module i2c_master_byte_engine (
  input  logic          clk_i,
  input  logic          rst_ni,
  i2cmbe_req_if.sink    req_i,
  i2cmbe_res_if.source  res_o,
  i2cmbe_cfg_if.sink    cfg_i
);

  i2cmbe_pkg::req_t             req;
  i2cmbe_pkg::res_t             res;
  logic [i2cmbe_pkg::DataW-1:0] ack_timeout;
  logic                         buf_ready;
  logic                         accept;

  assign req.req_type = req_i.req_type;
  assign req.wr_data  = req_i.wr_data;
  assign req.send_ack = req_i.send_ack;
  assign req.sda_in   = req_i.sda_in;

  assign req_i.ready = buf_ready;
  assign accept      = req_i.valid & buf_ready;

  i2cmbe_timeout_reg u_timeout (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_i),
    .ack_timeout_o (ack_timeout)
  );

  i2cmbe_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_i         (req),
    .ack_timeout_i (ack_timeout),
    .res_o         (res)
  );

  i2cmbe_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (res),
    .ready_o (buf_ready),
    .res_o   (res_o)
  );

endmodule

// ===== test/i2c_master_byte_engine_tb.sv =====
// Self-checking testbench for the I2C master byte engine: bus ticks are driven
// from a queue and every result is compared with an in-bench sequencer model.
// Depends on i2cmbe_pkg, the three channel interfaces and the engine RTL.
module i2c_master_byte_engine_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cmbe_pkg::*;

  localparam logic [CmdW-1:0] CMD_RSVD6 = 3'd6;
  localparam logic [CmdW-1:0] CMD_RSVD7 = 3'd7;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  i2cmbe_req_if req_if ();
  i2cmbe_res_if res_if ();
  i2cmbe_cfg_if cfg_if ();

  i2c_master_byte_engine uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  req_t tick_queue[$];
  res_t line_states_due[$];
  logic req_taken = 1'b0;
  logic hold_off = 1'b0;
  logic calm = 1'b0;
  int error_count = 0;
  int quiet_cycles = 0;
  int work_ticks = 0;
  int gen_timeout = int'(ACK_TIMEOUT_RST);

  // Sequencer state mirrored from the engine.
  logic [CmdW-1:0]  bus_cmd = CMD_NONE;
  logic [2:0]       bus_phase = '0;
  logic [3:0]       bit_count = '0;
  logic [DataW-1:0] shifter = '0;
  logic [DataW-1:0] poll_count = '0;
  logic             scl_q = 1'b1;
  logic             sda_q = 1'b1;
  logic             answer_ack = 1'b0;
  logic             fail_q = 1'b0;
  logic             fail_armed = 1'b0;
  logic [DataW-1:0] last_read = '0;
  logic [DataW-1:0] timeout_q = ACK_TIMEOUT_RST;

  task automatic report_mismatch(input string msg);
    if (error_count < 100) $display("mismatch at %0t ns: %s", $time, msg);
    error_count++;
  endtask

  function automatic bit stop_step();
    if (bus_phase == 3'd0) begin
      scl_q = 1'b0;
      sda_q = 1'b0;
      bus_phase = 3'd1;
      return 1'b0;
    end
    if (bus_phase == 3'd1) begin
      scl_q = 1'b1;
      bus_phase = 3'd2;
      return 1'b0;
    end
    sda_q = 1'b1;
    if (fail_armed) begin
      fail_q = 1'b1;
      fail_armed = 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic bit advance_bus(input logic sda);
    case (bus_cmd)
      CMD_START: begin
        case (bus_phase)
          3'd0: begin sda_q = 1'b1; bus_phase = 3'd1; end
          3'd1: begin scl_q = 1'b1; bus_phase = 3'd2; end
          3'd2: begin sda_q = 1'b0; bus_phase = 3'd3; end
          default: begin scl_q = 1'b0; return 1'b1; end
        endcase
        return 1'b0;
      end
      CMD_STOP: return stop_step();
      CMD_WRITE: begin
        if (bit_count < 4'd8) begin
          if (bus_phase == 3'd0) begin
            scl_q = 1'b0;
            sda_q = shifter[7];
            bus_phase = 3'd1;
          end else begin
            scl_q = 1'b1;
            shifter = shifter << 1;
            bit_count++;
            bus_phase = 3'd0;
          end
          return 1'b0;
        end
        scl_q = 1'b0;
        return 1'b1;
      end
      CMD_READ: begin
        if (bit_count < 4'd8) begin
          if (bus_phase == 3'd0) begin
            scl_q = 1'b0;
            sda_q = 1'b1;
            bus_phase = 3'd1;
          end else begin
            scl_q = 1'b1;
            shifter = {shifter[6:0], sda};
            bit_count++;
            bus_phase = 3'd0;
            if (bit_count == 4'd8) last_read = shifter;
          end
          return 1'b0;
        end
        case (bus_phase)
          3'd0: begin scl_q = 1'b0; sda_q = !answer_ack; bus_phase = 3'd1; end
          3'd1: begin scl_q = 1'b1; bus_phase = 3'd2; end
          default: begin scl_q = 1'b0; return 1'b1; end
        endcase
        return 1'b0;
      end
      CMD_WAIT: begin
        if (bus_phase == 3'd0) begin
          scl_q = 1'b1;
          sda_q = 1'b1;
          bus_phase = 3'd1;
          return 1'b0;
        end
        if (!sda) begin
          scl_q = 1'b0;
          return 1'b1;
        end
        if (poll_count >= timeout_q) begin
          // Timed out: the stop condition starts on this very tick.
          fail_armed = 1'b1;
          bus_cmd = CMD_STOP;
          bus_phase = 3'd0;
          return stop_step();
        end
        poll_count++;
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic res_t next_bus_state(input req_t r);
    res_t o;
    bit fin;
    fin = 1'b0;
    if (bus_cmd == CMD_NONE && r.req_type >= CMD_START && r.req_type <= CMD_WAIT) begin
      bus_cmd = r.req_type;
      bus_phase = 3'd0;
      bit_count = 4'd0;
      poll_count = '0;
      fail_armed = 1'b0;
      if (r.req_type == CMD_WRITE) shifter = r.wr_data;
      if (r.req_type == CMD_READ) begin
        shifter = '0;
        answer_ack = r.send_ack;
      end
      if (r.req_type == CMD_WAIT) fail_q = 1'b0;
    end
    if (bus_cmd != CMD_NONE) begin
      fin = advance_bus(r.sda_in);
      if (fin) begin
        bus_cmd = CMD_NONE;
        bus_phase = 3'd0;
      end
    end
    o.scl_out = scl_q;
    o.sda_out = sda_q;
    o.busy_res = (bus_cmd != CMD_NONE);
    o.done_res = fin;
    o.rd_data = last_read;
    o.ack_fail = fail_q;
    return o;
  endfunction

  always @(negedge clk) begin : drive_ticks
    req_t nxt;
    if (!rst_n) begin
      req_if.valid <= 1'b0;
    end else if (!req_if.valid || req_taken) begin
      if (tick_queue.size() != 0 && (calm || $urandom_range(0, 99) >= 34)) begin
        nxt = tick_queue.pop_front();
        req_if.valid <= 1'b1;
        req_if.req_type <= nxt.req_type;
        req_if.wr_data <= nxt.wr_data;
        req_if.send_ack <= nxt.send_ack;
        req_if.sda_in <= nxt.sda_in;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : drive_ready
    if (!rst_n) res_if.ready <= 1'b0;
    else res_if.ready <= !hold_off && (calm || $urandom_range(0, 99) >= 34);
  end

  always @(posedge clk) begin : check_results
    req_t taken;
    res_t got;
    res_t want;
    req_taken <= req_if.valid && req_if.ready;
    if (res_if.valid && res_if.ready) begin
      got = {res_if.scl_out, res_if.sda_out, res_if.busy_res, res_if.done_res,
             res_if.rd_data, res_if.ack_fail};
      if (line_states_due.size() == 0) begin
        report_mismatch($sformatf("result %h with nothing outstanding", got));
      end else begin
        want = line_states_due.pop_front();
        if (got.scl_out !== want.scl_out)
          report_mismatch($sformatf("scl_out %b, want %b", got.scl_out, want.scl_out));
        if (got.sda_out !== want.sda_out)
          report_mismatch($sformatf("sda_out %b, want %b", got.sda_out, want.sda_out));
        if (got.busy_res !== want.busy_res)
          report_mismatch($sformatf("busy_res %b, want %b", got.busy_res, want.busy_res));
        if (got.done_res !== want.done_res)
          report_mismatch($sformatf("done_res %b, want %b", got.done_res, want.done_res));
        if (got.rd_data !== want.rd_data)
          report_mismatch($sformatf("rd_data %h, want %h", got.rd_data, want.rd_data));
        if (got.ack_fail !== want.ack_fail)
          report_mismatch($sformatf("ack_fail %b, want %b", got.ack_fail, want.ack_fail));
      end
    end
    if (req_if.valid && req_if.ready) begin
      taken = {req_if.req_type, req_if.wr_data, req_if.send_ack, req_if.sda_in};
      line_states_due.push_back(next_bus_state(taken));
    end
  end

  always @(posedge clk) begin : watchdog
    if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (rst_n) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("i2c_master_byte_engine_tb: errors");
        $finish;
      end
    end
  end

  task automatic settle();
    @(posedge clk);
    #1;
  endtask

  task automatic add_tick(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                          input logic ack, input logic sda);
    req_t r;
    r.req_type = cmd;
    r.wr_data = data;
    r.send_ack = ack;
    r.sda_in = sda;
    tick_queue.push_back(r);
  endtask

  // Queues one command and the ticks that carry it to completion. For a read,
  // data is the byte the slave presents; for an acknowledge wait, polls is the
  // number of high polls before SDA goes low (beyond the timeout it fails).
  task automatic add_command(input logic [CmdW-1:0] cmd, input logic [DataW-1:0] data,
                             input logic ack, input int polls);
    int len;
    logic s;
    case (cmd)
      CMD_START: len = 4;
      CMD_STOP:  len = 3;
      CMD_WRITE: len = 17;
      CMD_READ:  len = 19;
      CMD_WAIT:  len = (polls > gen_timeout) ? gen_timeout + 4 : polls + 2;
      default:   len = 1;
    endcase
    if (cmd >= CMD_START && cmd <= CMD_WAIT) work_ticks += len;
    for (int t = 1; t <= len; t++) begin
      s = 1'($urandom_range(0, 1));
      if (cmd == CMD_READ && t % 2 == 0 && t <= 16) s = data[8 - t / 2];
      if (cmd == CMD_WAIT && t > 1) begin
        if (t - 1 <= polls && t - 1 <= gen_timeout + 1) s = 1'b1;
        else if (polls <= gen_timeout) s = 1'b0;
      end
      if (t == 1) add_tick(cmd, data, ack, s);
      else add_tick(CmdW'($urandom_range(0, 7)), DataW'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)), s);
    end
  endtask

  task automatic add_random_session(input int budget);
    int first;
    int cap;
    int polls;
    logic [CmdW-1:0] cmd;
    logic [DataW-1:0] data;
    first = work_ticks;
    while (work_ticks - first < budget) begin
      if ($urandom_range(0, 99) < 88) begin
        cmd = CmdW'($urandom_range(CMD_START, CMD_WAIT));
        case ($urandom_range(0, 7))
          0: data = 8'h00;
          1: data = 8'hFF;
          default: data = DataW'($urandom_range(0, 255));
        endcase
        cap = (gen_timeout < 6) ? gen_timeout : 6;
        if ($urandom_range(0, (gen_timeout > 20) ? 11 : 3) == 0) polls = gen_timeout + 1;
        else polls = $urandom_range(0, cap);
        add_command(cmd, data, 1'($urandom_range(0, 1)), polls);
        repeat ($urandom_range(0, 2)) begin
          case ($urandom_range(0, 2))
            0: cmd = CMD_NONE;
            1: cmd = CMD_RSVD6;
            default: cmd = CMD_RSVD7;
          endcase
          add_command(cmd, DataW'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          add_tick(CmdW'($urandom_range(0, 7)), DataW'($urandom_range(0, 255)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
          work_ticks++;
        end
      end
    end
  endtask

  // Drains every queued tick and result, then pads with empty ticks until the
  // sequencer has no command in progress, so that the timeout may be rewritten.
  task automatic wait_idle();
    do begin
      while (tick_queue.size() != 0 || req_if.valid || line_states_due.size() != 0)
        settle();
      if (bus_cmd != CMD_NONE)
        repeat (8) add_tick(CMD_NONE, 8'h00, 1'b0, 1'($urandom_range(0, 1)));
    end while (bus_cmd != CMD_NONE);
  endtask

  initial begin
    logic [DataW-1:0] tmo;
    req_if.valid = 1'b0;
    req_if.req_type = CMD_NONE;
    req_if.wr_data = '0;
    req_if.send_ack = 1'b0;
    req_if.sda_in = 1'b1;
    res_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.ack_timeout = '0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    settle();

    add_command(CMD_START, 8'h00, 1'b0, 0);
    add_command(CMD_WRITE, 8'hFF, 1'b0, 0);
    add_command(CMD_WAIT, 8'h00, 1'b0, 0);
    add_command(CMD_WRITE, 8'h00, 1'b1, 0);
    add_command(CMD_WAIT, 8'hFF, 1'b1, 3);
    add_command(CMD_READ, 8'hFF, 1'b1, 0);
    add_command(CMD_READ, 8'h00, 1'b0, 0);
    add_command(CMD_RSVD6, 8'hFF, 1'b1, 0);
    add_command(CMD_RSVD7, 8'h00, 1'b0, 0);
    add_command(CMD_NONE, 8'hFF, 1'b1, 0);
    add_command(CMD_WAIT, 8'h00, 1'b0, int'(ACK_TIMEOUT_RST));
    add_command(CMD_WAIT, 8'h00, 1'b0, int'(ACK_TIMEOUT_RST) + 1);
    add_command(CMD_WRITE, 8'h5A, 1'b0, 0);
    add_command(CMD_READ, 8'hA5, 1'b1, 0);
    add_command(CMD_STOP, 8'h00, 1'b0, 0);
    wait_idle();

    for (int p = 0; p < 6; p++) begin
      case (p)
        0: tmo = 8'd1;
        1: tmo = 8'd255;
        2: tmo = 8'd0;
        default: tmo = DataW'($urandom_range(2, 40));
      endcase
      @(negedge clk);
      cfg_if.valid <= 1'b1;
      cfg_if.ack_timeout <= tmo;
      do @(posedge clk); while (cfg_if.ready !== 1'b1);
      timeout_q = tmo;
      gen_timeout = int'(tmo);
      @(negedge clk);
      cfg_if.valid <= 1'b0;
      repeat (3) settle();

      calm = (p == 1);
      add_random_session(160);
      if (p == 0) begin
        // Receiver holds off while ticks keep coming, so the input backs up.
        @(negedge clk);
        hold_off <= 1'b1;
        repeat (120) @(negedge clk);
        hold_off <= 1'b0;
        settle();
      end
      wait_idle();
    end
    calm = 1'b0;

    repeat (4) settle();
    if (line_states_due.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", line_states_due.size()));
    if (error_count == 0) $display("i2c_master_byte_engine_tb: clean");
    else $display("i2c_master_byte_engine_tb: errors");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/i2cmbe_pkg.sv
rtl/i2cmbe_req_if.sv
rtl/i2cmbe_res_if.sv
rtl/i2cmbe_cfg_if.sv
rtl/i2cmbe_core.sv
rtl/i2cmbe_out_buf.sv
rtl/i2cmbe_timeout_reg.sv
rtl/i2c_master_byte_engine.sv
test/i2c_master_byte_engine_tb.sv
